### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the indicator LSB embedder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset.
`define ILSE_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When ante holds, cons must hold in the following cycle.
`define ILSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ilse_pkg.sv
// ----------------------------------------------------------------------------
// ilse_pkg
// Shared types and constants of the indicator LSB embedder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilse_pkg;

    // APB register map (byte addresses 0, 4, 8)
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_IND_CH  = 2'd0;
    localparam t_reg_idx REG_BPP     = 2'd1;
    localparam t_reg_idx REG_MSG_LEN = 2'd2;

    // opcodes of an input beat
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_UNDERRUN = 2'd1;
    localparam t_status ST_REJECT   = 2'd2;

    // channel codes
    typedef logic [1:0] t_chan;
    localparam t_chan CH_RED   = 2'd0;
    localparam t_chan CH_GREEN = 2'd1;
    localparam t_chan CH_BLUE  = 2'd2;

    localparam int LEN_BYTES = 4;   // length header bytes ahead of the message
    localparam int MAX_BPP   = 8;

    // bits handed from the stream buffer to the pixel datapath
    typedef struct packed {
        logic       embed;   // pixel takes cnt stream bits
        logic [3:0] cnt;     // number of bits, 0..8
        logic [7:0] bits;    // right aligned, oldest bit highest
    } t_take;

endpackage

### hdl/ilse_if.sv
// ----------------------------------------------------------------------------
// ilse_if
// Valid/ready channel interfaces for input and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ilse_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] msg_byte;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output opcode, output msg_byte, output red_in,
                    output green_in, output blue_in, input ready);
    modport sink   (input valid, input opcode, input msg_byte, input red_in,
                    input green_in, input blue_in, output ready);
endinterface

interface ilse_out_if;
    logic       valid;
    logic       ready;
    logic       is_pixel;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [1:0] status;
    logic       all_embedded;

    modport source (output valid, output is_pixel, output red_out, output green_out,
                    output blue_out, output status, output all_embedded, input ready);
    modport sink   (input valid, input is_pixel, input red_out, input green_out,
                    input blue_out, input status, input all_embedded, output ready);
endinterface

### hdl/ilse_regs.sv
// ----------------------------------------------------------------------------
// ilse_regs
// APB configuration registers with clamped copies for the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilse_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ilse_pkg::ADDR_W-1:0] paddr,
    input  logic [ilse_pkg::DATA_W-1:0] pwdata,
    output logic [ilse_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [1:0]                 o_ind_ch,
    output logic [3:0]                 o_bpp,
    output logic [31:0]                o_msg_len
);
    import ilse_pkg::*;

    logic [1:0]  r_ind_ch;
    logic [3:0]  r_bpp;
    logic [31:0] r_msg_len;
    logic        wr_en;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ind_ch  <= 2'd0;
            r_bpp     <= 4'd1;
            r_msg_len <= 32'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IND_CH:  r_ind_ch  <= pwdata[1:0];
                REG_BPP:     r_bpp     <= pwdata[3:0];
                REG_MSG_LEN: r_msg_len <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IND_CH:  prdata = {30'd0, r_ind_ch};
            REG_BPP:     prdata = {28'd0, r_bpp};
            REG_MSG_LEN: prdata = r_msg_len;
            default:     prdata = '0;
        endcase
    end

    // channel code 3 acts as red; bpp clamped to 1..8
    assign o_ind_ch  = (r_ind_ch == 2'd3) ? CH_RED : r_ind_ch;
    assign o_bpp     = (r_bpp == 4'd0) ? 4'd1 :
                       (r_bpp > 4'(MAX_BPP)) ? 4'(MAX_BPP) : r_bpp;
    assign o_msg_len = r_msg_len;

endmodule

### hdl/ilse_stream.sv
// ----------------------------------------------------------------------------
// ilse_stream
// Bit buffer, length header refill, byte push and pixel bit take-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilse_stream (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_opcode,
    input  logic [7:0]      i_msg_byte,
    input  logic [3:0]      i_bpp,
    input  logic [31:0]     i_msg_len,
    output ilse_pkg::t_take o_take,
    output logic [1:0]      o_status,
    output logic            o_all_embedded
);
    import ilse_pkg::*;

    logic [15:0] r_buf,   n_buf;
    logic [4:0]  r_bb,    n_bb;
    logic [32:0] r_bq,    n_bq;
    logic [35:0] r_total, n_total;

    logic [15:0] buf_a, buf_b;
    logic [4:0]  bb_a,  bb_b;
    logic [32:0] bq_a,  bq_b;
    logic [32:0] byte_lim;
    logic [35:0] stream_bits, diff;
    logic        done, rem_small, reject, underrun;
    logic [3:0]  cnt;
    logic [4:0]  bb_left;
    logic [15:0] ext;
    logic [8:0]  nmask;
    logic [16:0] keep;

    function automatic logic [7:0] f_len_byte(input logic [31:0] len,
                                              input logic [1:0] idx);
        return len[{idx, 3'b000} +: 8];
    endfunction

    always_comb begin
        // length header refill: at most two bytes per beat
        buf_a = r_buf;
        bb_a  = r_bb;
        bq_a  = r_bq;
        if (r_bq[32:2] == '0 && r_bb <= 5'd8) begin
            buf_a = {r_buf[7:0], f_len_byte(i_msg_len, r_bq[1:0])};
            bb_a  = r_bb + 5'd8;
            bq_a  = r_bq + 33'd1;
        end
        buf_b = buf_a;
        bb_b  = bb_a;
        bq_b  = bq_a;
        if (bq_a[32:2] == '0 && bb_a <= 5'd8) begin
            buf_b = {buf_a[7:0], f_len_byte(i_msg_len, bq_a[1:0])};
            bb_b  = bb_a + 5'd8;
            bq_b  = bq_a + 33'd1;
        end

        byte_lim    = {1'b0, i_msg_len} + 33'(LEN_BYTES);
        reject      = (bb_b > 5'd8) || (bq_b >= byte_lim);

        stream_bits = {byte_lim, 3'b000};
        done        = (r_total >= stream_bits);
        diff        = stream_bits - r_total;
        rem_small   = (diff[35:4] == '0) && (diff[3:0] <= i_bpp);
        cnt         = done ? 4'd0 : (rem_small ? diff[3:0] : i_bpp);
        underrun    = (cnt != 4'd0) && (bb_b < {1'b0, cnt});

        bb_left     = bb_b - {1'b0, cnt};
        ext         = buf_b >> bb_left;
        nmask       = (9'd1 << cnt) - 9'd1;
        keep        = (17'd1 << bb_left) - 17'd1;

        o_take.embed = (cnt != 4'd0) && !underrun;
        o_take.cnt   = cnt;
        o_take.bits  = ext[7:0] & nmask[7:0];

        o_status = ST_OK;
        if (i_opcode == OP_PUSH) begin
            if (reject) o_status = ST_REJECT;
            o_all_embedded = done;
        end else begin
            if (underrun) o_status = ST_UNDERRUN;
            o_all_embedded = done || (o_take.embed && rem_small);
        end

        n_buf   = r_buf;
        n_bb    = r_bb;
        n_bq    = r_bq;
        n_total = r_total;
        if (i_step) begin
            n_buf = buf_b;
            n_bb  = bb_b;
            n_bq  = bq_b;
            if (i_opcode == OP_PUSH) begin
                if (!reject) begin
                    n_buf = {buf_b[7:0], i_msg_byte};
                    n_bb  = bb_b + 5'd8;
                    n_bq  = bq_b + 33'd1;
                end
            end else if (o_take.embed) begin
                n_buf   = buf_b & keep[15:0];
                n_bb    = bb_left;
                n_total = r_total + 36'(cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_bb    <= '0;
            r_bq    <= '0;
            r_total <= '0;
        end else begin
            r_buf   <= n_buf;
            r_bb    <= n_bb;
            r_bq    <= n_bq;
            r_total <= n_total;
        end
    end

    `ILSE_ASSERT_ALWAYS(a_bb_max, i_clk, i_rst_n, r_bb <= 5'd16, "bit buffer overfilled")
    `ILSE_ASSERT_NEXT(a_total_adv, i_clk, i_rst_n, i_step && (i_opcode == OP_PIXEL) && o_take.embed, r_total == $past(r_total) + 36'($past(o_take.cnt)), "embedded bit count mismatch")

endmodule

### hdl/ilse_pixel.sv
// ----------------------------------------------------------------------------
// ilse_pixel
// Data channel pick, indicator bit write and data bit insertion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilse_pixel (
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    input  logic [1:0]      i_ind_ch,
    input  logic [3:0]      i_bpp,
    input  ilse_pkg::t_take i_take,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);
    import ilse_pkg::*;

    logic        flag;
    t_chan       data_ch;
    logic [7:0]  ch [3];
    logic [3:0]  shift;
    logic [8:0]  nmask;
    logic [7:0]  fmask;
    logic [7:0]  ins;

    always_comb begin
        ch[0] = i_red;
        ch[1] = i_green;
        ch[2] = i_blue;

        case (i_ind_ch)
            CH_GREEN: begin
                flag    = !(i_red > i_blue);
                data_ch = (i_red > i_blue) ? CH_BLUE : CH_RED;
            end
            CH_BLUE: begin
                flag    = !(i_green > i_red);
                data_ch = (i_green > i_red) ? CH_RED : CH_GREEN;
            end
            default: begin
                flag    = (i_green > i_blue);
                data_ch = (i_green > i_blue) ? CH_BLUE : CH_GREEN;
            end
        endcase

        case (i_ind_ch)
            CH_GREEN: ch[1][0] = flag;
            CH_BLUE:  ch[2][0] = flag;
            default:  ch[0][0] = flag;
        endcase

        // stream bits go to the top of the data field
        shift = i_bpp - i_take.cnt;
        nmask = (9'd1 << i_take.cnt) - 9'd1;
        fmask = nmask[7:0] << shift;
        ins   = i_take.bits << shift;

        if (i_take.embed) begin
            case (data_ch)
                CH_GREEN: ch[1] = (ch[1] & ~fmask) | ins;
                CH_BLUE:  ch[2] = (ch[2] & ~fmask) | ins;
                default:  ch[0] = (ch[0] & ~fmask) | ins;
            endcase
        end

        o_red   = ch[0];
        o_green = ch[1];
        o_blue  = ch[2];
    end

endmodule

### hdl/indicator_lsb_stego_embedder_unit.sv
// ----------------------------------------------------------------------------
// indicator_lsb_stego_embedder_unit
// Each beat passes the input register, one step of logic and the result
// register, with the stream state updated in that step. The unit takes one
// beat per cycle while the result side is ready to accept.
// Reset (i_rst_n, synchronous, active low): pipeline empty, stream state
// cleared, registers at indicator red, 1 bit per pixel, length 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indicator_lsb_stego_embedder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ilse_in_if.sink                     i_in,
    ilse_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ilse_pkg::ADDR_W-1:0] paddr,
    input  logic [ilse_pkg::DATA_W-1:0] pwdata,
    output logic [ilse_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import ilse_pkg::*;

    // configuration, already clamped to legal values
    logic [1:0]  ind_ch;
    logic [3:0]  bpp;
    logic [31:0] msg_len;

    // input stage
    logic        r_s1_valid, n_s1_valid;
    logic        r_s1_opcode;
    logic [7:0]  r_s1_msg;
    logic [7:0]  r_s1_red, r_s1_green, r_s1_blue;

    // result stage
    logic        r_out_valid, n_out_valid;
    logic        r_out_is_pixel;
    logic [7:0]  r_out_red, r_out_green, r_out_blue;
    logic [1:0]  r_out_status;
    logic        r_out_done;

    logic        in_fire, s1_adv;
    t_take       take;
    logic [1:0]  st_status;
    logic        st_done;
    logic [7:0]  px_red, px_green, px_blue;

    ilse_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_ind_ch  (ind_ch),
        .o_bpp     (bpp),
        .o_msg_len (msg_len)
    );

    // Stream state advances exactly when the input stage moves into the
    // result register, so one beat is one state step.
    ilse_stream u_stream (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (s1_adv),
        .i_opcode       (r_s1_opcode),
        .i_msg_byte     (r_s1_msg),
        .i_bpp          (bpp),
        .i_msg_len      (msg_len),
        .o_take         (take),
        .o_status       (st_status),
        .o_all_embedded (st_done)
    );

    ilse_pixel u_pixel (
        .i_red    (r_s1_red),
        .i_green  (r_s1_green),
        .i_blue   (r_s1_blue),
        .i_ind_ch (ind_ch),
        .i_bpp    (bpp),
        .i_take   (take),
        .o_red    (px_red),
        .o_green  (px_green),
        .o_blue   (px_blue)
    );

    // Handshake: the result register may hold a stalled beat while the
    // input stage still takes a new one; the input stage refills in the
    // same cycle it drains.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire)     n_s1_valid = 1'b1;
        else if (s1_adv) n_s1_valid = 1'b0;

        n_out_valid = r_out_valid;
        if (s1_adv)           n_out_valid = 1'b1;
        else if (o_out.ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_opcode <= i_in.opcode;
            r_s1_msg    <= i_in.msg_byte;
            r_s1_red    <= i_in.red_in;
            r_s1_green  <= i_in.green_in;
            r_s1_blue   <= i_in.blue_in;
        end
        if (s1_adv) begin
            r_out_is_pixel <= (r_s1_opcode == OP_PIXEL);
            // a byte push reports a black pixel
            r_out_red      <= (r_s1_opcode == OP_PIXEL) ? px_red   : 8'd0;
            r_out_green    <= (r_s1_opcode == OP_PIXEL) ? px_green : 8'd0;
            r_out_blue     <= (r_s1_opcode == OP_PIXEL) ? px_blue  : 8'd0;
            r_out_status   <= st_status;
            r_out_done     <= st_done;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.is_pixel     = r_out_is_pixel;
    assign o_out.red_out      = r_out_red;
    assign o_out.green_out    = r_out_green;
    assign o_out.blue_out     = r_out_blue;
    assign o_out.status       = r_out_status;
    assign o_out.all_embedded = r_out_done;

    // a stalled input stage keeps its beat
    `ILSE_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid, "input stage beat lost while stalled")
    // underrun only on pixels, reject only on pushes
    `ILSE_ASSERT_ALWAYS(a_status_kind, i_clk, i_rst_n, !r_out_valid || ((r_out_status != ST_UNDERRUN || r_out_is_pixel) && (r_out_status != ST_REJECT || !r_out_is_pixel)), "status does not match beat kind")

endmodule
